// File: rtl/avt_pkg.sv
// Shared types, codes and helpers of the attention value table.
`default_nettype none

package avt_pkg;

  localparam int VAL_W  = 24;
  localparam int FRAC_W = 16;
  localparam int SAL_W  = 17;
  localparam int ENT_W  = 8;
  localparam int CNT_W  = 9;
  localparam int CTR_W  = 32;

  localparam logic [SAL_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_DECAY  = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] CFG_BASE  = 3'd0;
  localparam logic [2:0] CFG_MIN   = 3'd1;
  localparam logic [2:0] CFG_MAX   = 3'd2;
  localparam logic [2:0] CFG_FRAC  = 3'd3;
  localparam logic [2:0] CFG_FOCUS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC1,
    ST_ALLOC2,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_FIN
  } avt_state_t;

  // Saturated configuration seen by the arithmetic.
  typedef struct packed {
    logic [SAL_W-1:0] base_sat;
    logic [SAL_W-1:0] keep;
    logic [VAL_W-1:0] min_v;
    logic [VAL_W-1:0] hi_v;
  } avt_cfg_t;

  // Arithmetic results handed back to the sequencer.
  typedef struct packed {
    logic [VAL_W-1:0] alloc_val;
    logic [VAL_W-1:0] dec_val;
    logic             dec_drop;
  } avt_dp_res_t;

  function automatic logic [VAL_W-1:0] clamp_val(input logic [VAL_W-1:0] v,
                                                 input logic [VAL_W-1:0] lo,
                                                 input logic [VAL_W-1:0] hi);
    logic [VAL_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/avt_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface avt_in_if import avt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       op;
  logic [ENT_W-1:0] entry;
  logic [SAL_W-1:0] salience;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, output op, output entry, output salience,
                  output new_value, input ready);
  modport sink   (input valid, input op, input entry, input salience,
                  input new_value, output ready);
endinterface

interface avt_out_if import avt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value_out;
  logic             is_tracked;
  logic             in_focus;
  logic [CNT_W-1:0] tracked_count;
  logic [CTR_W-1:0] allocation_count;
  logic [CTR_W-1:0] decay_count;

  modport source (output valid, output value_out, output is_tracked, output in_focus,
                  output tracked_count, output allocation_count, output decay_count,
                  input ready);
  modport sink   (input valid, input value_out, input is_tracked, input in_focus,
                  input tracked_count, input allocation_count, input decay_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/avt_value_ram.sv
// Value store: one write port, one read port with registered read data.
`default_nettype none

module avt_value_ram import avt_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/avt_datapath.sv
// Allocation and decay arithmetic, free-running registered stages.
`default_nettype none

module avt_datapath import avt_pkg::*; (
  input  wire logic             clk,
  input  wire avt_cfg_t         cfg,
  input  wire logic [SAL_W-1:0] salience,
  input  wire logic [VAL_W-1:0] rd_data,
  output avt_dp_res_t           res
);

  localparam int SQ_W  = 2 * SAL_W;
  localparam int PR_W  = 3 * SAL_W;
  localparam int DEC_W = VAL_W + SAL_W;

  logic [SAL_W-1:0] s_sat;
  logic [SAL_W-1:0] wgt;
  logic [SQ_W-1:0]  sq_r;
  logic [SQ_W-1:0]  lin_r;
  logic [PR_W-1:0]  prod_r;
  logic [PR_W-1:0]  acc;
  logic [DEC_W-1:0] dec_prod_r;
  logic [VAL_W-1:0] dec_next;

  assign s_sat = (salience > ONE_Q16) ? ONE_Q16 : salience;
  assign wgt   = ONE_Q16 - cfg.base_sat;

  // Stage 1: s*s, base*s and the decay product value*keep; stage 2: (1-base)*s*s.
  always_ff @(posedge clk) begin
    sq_r       <= {{SAL_W{1'b0}}, s_sat} * {{SAL_W{1'b0}}, s_sat};
    lin_r      <= {{SAL_W{1'b0}}, cfg.base_sat} * {{SAL_W{1'b0}}, s_sat};
    prod_r     <= {{(2*SAL_W){1'b0}}, wgt} * {{SAL_W{1'b0}}, sq_r};
    dec_prod_r <= {{SAL_W{1'b0}}, rd_data} * {{VAL_W{1'b0}}, cfg.keep};
  end

  assign acc      = PR_W'({lin_r, {FRAC_W{1'b0}}}) + prod_r;
  assign dec_next = dec_prod_r[VAL_W+FRAC_W-1:FRAC_W];

  assign res.alloc_val = clamp_val(VAL_W'(acc[2*FRAC_W+SAL_W-1:2*FRAC_W]),
                                   cfg.min_v, cfg.hi_v);
  assign res.dec_val   = clamp_val(dec_next, cfg.min_v, cfg.hi_v);
  assign res.dec_drop  = (dec_next <= cfg.min_v);

endmodule

`default_nettype wire

// File: rtl/attention_value_table_core.sv
// Attention value table top level: sequencer, tracked bits, counters, result register.
//
// The table holds one Q8.16 attention value per entry in a single-port-write,
// registered-read RAM, with a tracked bit per entry held in flip-flops that
// reset and the clear operation empty at once, so no clearing pass is needed.
// One request word is worked at a time; a new one is taken only when the
// sequencer is idle. Query and clear do one RAM read, allocate runs two
// multiplier stages before the clamped write, and a decay pass walks over
// every entry through the RAM port, read, multiply and write-back
// overlapped, then drains and reads the addressed entry. Only the lowest
// 256 entries are addressable by the 8-bit entry field, so the store is
// sized to at most 256 entries. The finished result waits in an output
// register and is held until taken; configuration writes must land while
// the block is idle.
`default_nettype none

module attention_value_table_core import avt_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data,
  avt_in_if.sink                in_if,
  avt_out_if.source             out_if
);

  localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  // Configuration registers.
  logic [SAL_W-1:0] base_r, frac_r;
  logic [VAL_W-1:0] min_r, max_r, focus_r;

  // Sequencer and latched request.
  avt_state_t       state_r, state_nxt;
  logic [2:0]       op_r;
  logic [ENT_W-1:0] idx_r;
  logic [SAL_W-1:0] sal_r;
  logic [VAL_W-1:0] nv_r;
  logic             ok_r;

  // Decay walk.
  logic [IW-1:0]    scan_r, scan_nxt;
  logic             p1_v_r, p1_v_nxt, p2_v_r;
  logic [IW-1:0]    p1_idx_r, p2_idx_r;

  // Table state outside the RAM.
  logic [DEPTH-1:0] trk_r, trk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CTR_W-1:0] acnt_r, acnt_nxt, dcnt_r, dcnt_nxt;

  // Result register.
  logic             ov_r, ov_nxt;
  logic [VAL_W-1:0] o_val_r;
  logic             o_trk_r, o_foc_r;
  logic [CNT_W-1:0] o_cnt_r;
  logic [CTR_W-1:0] o_acnt_r, o_dcnt_r;

  // Control.
  logic             in_fire, ent_ok, out_free;
  logic             fin_go, clr_go, decay_done, is_wr;
  logic             ram_re, ram_we;
  logic [IW-1:0]    ram_raddr, ram_waddr, widx;
  logic [VAL_W-1:0] ram_wdata, ram_rdata, wv, rv;
  logic             rt;
  avt_cfg_t         cfg;
  avt_dp_res_t      dp;

  assign in_fire  = in_if.valid && in_if.ready;
  assign ent_ok   = 32'(in_if.entry) < ENTRIES;
  assign out_free = !ov_r || out_if.ready;
  assign widx     = idx_r[IW-1:0];
  assign is_wr    = ok_r && ((op_r == OP_ALLOC) || (op_r == OP_UPDATE));

  // Saturate the weights and fold max below min into min.
  assign cfg.base_sat = (base_r > ONE_Q16) ? ONE_Q16 : base_r;
  assign cfg.keep     = ONE_Q16 - ((frac_r > ONE_Q16) ? ONE_Q16 : frac_r);
  assign cfg.min_v    = min_r;
  assign cfg.hi_v     = (max_r < min_r) ? min_r : max_r;

  avt_datapath u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .salience (sal_r),
    .rd_data  (ram_rdata),
    .res      (dp)
  );

  avt_value_ram #(.DEPTH(DEPTH), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_if.op)
            OP_ALLOC:  state_nxt = ent_ok ? ST_ALLOC1 : ST_READ;
            OP_UPDATE: state_nxt = ent_ok ? ST_FIN : ST_READ;
            OP_DECAY:  state_nxt = ST_SCAN;
            default:   state_nxt = ST_READ;
          endcase
        end
      end
      ST_ALLOC1: state_nxt = ST_ALLOC2;
      ST_ALLOC2: state_nxt = ST_FIN;
      ST_SCAN: begin
        if (scan_r == LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_v_r) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_if.ready = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = widx;
    fin_go      = 1'b0;
    clr_go      = 1'b0;
    decay_done  = 1'b0;
    scan_nxt    = scan_r;
    p1_v_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        clr_go      = in_fire && (in_if.op == OP_CLEAR);
        scan_nxt    = '0;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_r;
        p1_v_nxt  = trk_r[scan_r];
        scan_nxt  = scan_r + 1'b1;
      end
      ST_DRAIN: decay_done = !p1_v_r;
      ST_READ:  ram_re = 1'b1;
      ST_FIN:   fin_go = out_free;
      default: begin
        in_if.ready = 1'b0;
      end
    endcase
  end

  // Value written by allocate or update.
  assign wv = (op_r == OP_ALLOC) ? dp.alloc_val : clamp_val(nv_r, cfg.min_v, cfg.hi_v);

  // Decay write-back has the port to itself; never overlaps a finishing write.
  assign ram_we    = (fin_go && is_wr) || (p2_v_r && !dp.dec_drop);
  assign ram_waddr = p2_v_r ? p2_idx_r : widx;
  assign ram_wdata = p2_v_r ? dp.dec_val : wv;

  // Tracked bits and counters.
  always_comb begin
    trk_nxt  = trk_r;
    cnt_nxt  = cnt_r;
    acnt_nxt = acnt_r;
    dcnt_nxt = dcnt_r;
    if (clr_go) begin
      trk_nxt  = '0;
      cnt_nxt  = '0;
      acnt_nxt = '0;
      dcnt_nxt = '0;
    end
    if (fin_go && is_wr) begin
      if (!trk_r[widx]) begin
        trk_nxt[widx] = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
      end
      if (op_r == OP_ALLOC) acnt_nxt = acnt_r + 1'b1;
    end
    if (p2_v_r && dp.dec_drop) begin
      trk_nxt[p2_idx_r] = 1'b0;
      cnt_nxt           = cnt_r - 1'b1;
    end
    if (decay_done) dcnt_nxt = dcnt_r + 1'b1;
  end

  // Report the addressed entry after the operation.
  always_comb begin
    if (is_wr) begin
      rt = 1'b1;
      rv = wv;
    end else begin
      rt = ok_r && trk_r[widx];
      rv = rt ? ram_rdata : '0;
    end
  end

  assign ov_nxt = fin_go ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      trk_r   <= '0;
      cnt_r   <= '0;
      acnt_r  <= '0;
      dcnt_r  <= '0;
      ov_r    <= 1'b0;
      base_r  <= 17'd32768;
      min_r   <= '0;
      max_r   <= 24'd65536;
      frac_r  <= 17'd6554;
      focus_r <= 24'd32768;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      p1_v_r  <= p1_v_nxt;
      p2_v_r  <= p1_v_r;
      trk_r   <= trk_nxt;
      cnt_r   <= cnt_nxt;
      acnt_r  <= acnt_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data[SAL_W-1:0];
          CFG_MIN:   min_r   <= cfg_data;
          CFG_MAX:   max_r   <= cfg_data;
          CFG_FRAC:  frac_r  <= cfg_data[SAL_W-1:0];
          CFG_FOCUS: focus_r <= cfg_data;
          default: begin
            base_r <= base_r;
          end
        endcase
      end
    end
  end

  // Payload registers: latch the request word, advance the walk, hold results.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_if.op;
      idx_r <= in_if.entry;
      sal_r <= in_if.salience;
      nv_r  <= in_if.new_value;
      ok_r  <= ent_ok;
    end
    p1_idx_r <= scan_r;
    p2_idx_r <= p1_idx_r;
    if (fin_go) begin
      o_val_r  <= rv;
      o_trk_r  <= rt;
      o_foc_r  <= rt && (rv >= focus_r);
      o_cnt_r  <= cnt_nxt;
      o_acnt_r <= acnt_nxt;
      o_dcnt_r <= dcnt_r;
    end
  end

  assign out_if.valid            = ov_r;
  assign out_if.value_out        = o_val_r;
  assign out_if.is_tracked       = o_trk_r;
  assign out_if.in_focus         = o_foc_r;
  assign out_if.tracked_count    = o_cnt_r;
  assign out_if.allocation_count = o_acnt_r;
  assign out_if.decay_count      = o_dcnt_r;

  // The count must always match the tracked bits.
  a_cnt_matches : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(trk_r)))
    else $error("tracked count out of step with tracked bits");

  // The decay pipeline is empty whenever a new word can be taken.
  a_idle_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!p1_v_r && !p2_v_r))
    else $error("decay write-back pending while idle");

  // No write may land while the addressed entry is being read for the result.
  a_no_wr_read : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !ram_we)
    else $error("table write during result read");

  // A finished result is only produced with room in the result register.
  a_fin_room : assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> ov_r)
    else $error("result lost at finish");

endmodule

`default_nettype wire
